// ===== design/dtb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtb_pkg
// Shared types and constants of the dual token bucket connection limiter.
// ----------------------------------------------------------------------------
package dtb_pkg;

	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLICY_COST  = 3'd0,
		REG_POLICY_CAP   = 3'd1,
		REG_POLICY_INIT  = 3'd2,
		REG_POLICY_START = 3'd3,
		REG_SOURCE_COST  = 3'd4,
		REG_SOURCE_CAP   = 3'd5,
		REG_SOURCE_INIT  = 3'd6,
		REG_LIFETIME     = 3'd7
	} reg_idx_t;

	localparam logic [31:0] LIFETIME_RESET = 32'd20000;
	localparam logic FUNC_CONN  = 1'b0;
	localparam logic FUNC_SWEEP = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_SWEEP_LAST,
		ST_POL_REFILL,
		ST_POL_DEBIT,
		ST_SEARCH,
		ST_SEARCH_LAST,
		ST_SRC_READ,
		ST_SRC_REFILL,
		ST_SRC_DEBIT,
		ST_DONE
	} state_t;

	// refill: credit + elapsed * rate, capped (all in wide arithmetic)
	typedef struct packed {
		logic [31:0] credit;
		logic [31:0] elapsed;
		logic [31:0] cap;
	} refill_req_t;

endpackage

// ===== design/dtb_refill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtb_refill
// Shared bucket refill unit: credit plus elapsed ticks times rate, capped.
// One registered stage; the rate multiply is a constant shift-scale.
// ----------------------------------------------------------------------------
module dtb_refill import dtb_pkg::*; #(
	parameter int unsigned CREDITS_PER_TICK = 32
) (
	input  logic        clk,
	input  refill_req_t req,
	output logic [31:0] result
);
	localparam int unsigned RW = 43;

	logic [RW-1:0] sum;
	logic [RW-1:0] prod;

	// elapsed (32b) times rate (<= 11b) fits 43 bits
	always_comb begin
		prod = RW'(req.elapsed) * RW'(CREDITS_PER_TICK);
		sum  = prod + RW'(req.credit);
	end

	always_ff @(posedge clk) begin
		result <= (sum > RW'(req.cap)) ? req.cap : sum[31:0];
	end
endmodule

// ===== design/dual_token_bucket_conn_limiter_unit.sv =====
`timescale 1ns / 1ps
// A sweep walks the whole table once; a connection event may refill and debit the global
// bucket, walk the table one entry per cycle, then refill and debit the source bucket.
// A check-free event goes straight to done.
// One item at a time: busy is high meanwhile; the next start is taken in the done cycle.
// Results are strobed for one cycle by done; the receiver cannot stall.
// Reset clears registers, valid and reload bits at once; no clearing pass.
// ----------------------------------------------------------------------------
// dual_token_bucket_conn_limiter_unit
// Global and per-source token bucket limiter for new connections.
// ----------------------------------------------------------------------------
module dual_token_bucket_conn_limiter_unit import dtb_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES    = 256,
	parameter int unsigned CREDITS_PER_TICK = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [31:0] source_ip,
	input  logic [31:0] now,
	input  logic        is_new,
	output logic        done,
	output logic        matched,
	output logic        drop,
	output logic        table_full,
	output logic [8:0]  removed_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// config registers
	logic [31:0] pol_cost_q, pol_cap_q, pol_init_q, pol_start_q;
	logic [31:0] src_cost_q, src_cap_q, src_init_q, lifetime_q;
	logic [31:0] pol_credit_q, pol_last_q;

	// table: valid/reload in flops, payload in memories
	logic [TABLE_ENTRIES-1:0] valid_q, reload_q;
	logic [31:0] mem_addr [TABLE_ENTRIES];
	logic [31:0] mem_credit [TABLE_ENTRIES];
	logic [31:0] mem_last [TABLE_ENTRIES];
	logic [31:0] mem_exp [TABLE_ENTRIES];

	logic [31:0] rd_addr_q, rd_credit_q, rd_last_q, rd_exp_q;
	logic [AW-1:0] rd_idx_q, ptr_q, slot_q;
	logic [AW-1:0] rd_ptr;

	state_t state_q, state_d;
	logic [31:0] ip_q, now_q;
	logic        found_q, free_q, valid_rd_q;
	logic [8:0]  removed_q;
	logic        matched_q, drop_q, full_q;
	logic [31:0] src_credit;
	logic        reload_hit_q;

	refill_req_t rreq;
	logic [31:0] rres;

	dtb_refill #(.CREDITS_PER_TICK(CREDITS_PER_TICK)) u_refill (
		.clk(clk), .req(rreq), .result(rres)
	);

	assign cfg_ready = !busy;
	assign busy      = (state_q != ST_IDLE);

	// read address: walk pointer, or the chosen slot ahead of the source refill
	assign rd_ptr = (state_q == ST_SRC_READ) ? slot_q : ptr_q;

	// read port: registered read
	always_ff @(posedge clk) begin
		rd_addr_q   <= mem_addr[rd_ptr];
		rd_credit_q <= mem_credit[rd_ptr];
		rd_last_q   <= mem_last[rd_ptr];
		rd_exp_q    <= mem_exp[rd_ptr];
		rd_idx_q    <= rd_ptr;
	end

	always_comb begin
		rreq = '0;
		if (state_q == ST_POL_REFILL) begin
			rreq.credit  = pol_credit_q;
			rreq.elapsed = now_q - pol_last_q;
			rreq.cap     = pol_cap_q;
		end else begin
			rreq.credit  = reload_hit_q ? src_init_q : rd_credit_q;
			rreq.elapsed = now_q - rd_last_q;
			rreq.cap     = src_cap_q;
		end
	end

	logic last_ptr;
	assign last_ptr = (ptr_q == AW'(TABLE_ENTRIES - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) begin
				if (func == FUNC_SWEEP) state_d = ST_SWEEP;
				else if (is_new && (pol_cost_q != '0 || src_cost_q != '0))
					state_d = (pol_cost_q != '0) ? ST_POL_REFILL : ST_SEARCH;
				else state_d = ST_DONE;
			end
			ST_SWEEP:       if (last_ptr) state_d = ST_SWEEP_LAST;
			ST_SWEEP_LAST:  state_d = ST_DONE;
			ST_POL_REFILL:  state_d = ST_POL_DEBIT;
			ST_POL_DEBIT:   state_d = (rres > pol_cost_q && src_cost_q != '0) ?
				ST_SEARCH : ST_DONE;
			ST_SEARCH:      if (last_ptr) state_d = ST_SEARCH_LAST;
			ST_SEARCH_LAST: state_d = ST_SRC_READ;
			ST_SRC_READ:    state_d = (found_q || free_q) ? ST_SRC_REFILL : ST_DONE;
			ST_SRC_REFILL:  state_d = ST_SRC_DEBIT;
			ST_SRC_DEBIT:   state_d = ST_DONE;
			ST_DONE:        state_d = ST_IDLE;
			default:        state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// sequencer datapath and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_cost_q <= '0; pol_cap_q <= '0; pol_init_q <= '0; pol_start_q <= '0;
			src_cost_q <= '0; src_cap_q <= '0; src_init_q <= '0;
			lifetime_q <= LIFETIME_RESET;
			pol_credit_q <= '0; pol_last_q <= '0;
			valid_q <= '0; reload_q <= '0;
			ptr_q <= '0; slot_q <= '0;
			ip_q <= '0; now_q <= '0;
			found_q <= 1'b0; free_q <= 1'b0; valid_rd_q <= 1'b0;
			removed_q <= '0; matched_q <= 1'b0; drop_q <= 1'b0; full_q <= 1'b0;
			reload_hit_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			valid_rd_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (reg_idx_t'(cfg_index))
					REG_POLICY_COST:  pol_cost_q  <= cfg_data;
					REG_POLICY_CAP:   pol_cap_q   <= cfg_data;
					REG_POLICY_INIT:  pol_init_q  <= cfg_data;
					REG_POLICY_START: pol_start_q <= cfg_data;
					REG_SOURCE_COST:  src_cost_q  <= cfg_data;
					REG_SOURCE_CAP:   src_cap_q   <= cfg_data;
					REG_SOURCE_INIT:  src_init_q  <= cfg_data;
					REG_LIFETIME:     lifetime_q  <= cfg_data;
					default: ;
				endcase
				if (cfg_index == REG_POLICY_INIT) begin
					pol_credit_q <= cfg_data; pol_last_q <= pol_start_q;
				end else if (cfg_index == REG_POLICY_START) begin
					pol_credit_q <= pol_init_q; pol_last_q <= cfg_data;
				end else if (cfg_index == REG_POLICY_COST ||
					cfg_index == REG_POLICY_CAP) begin
					pol_credit_q <= pol_init_q; pol_last_q <= pol_start_q;
				end else if (cfg_index != REG_LIFETIME) begin
					reload_q <= '1;
				end
			end
			unique case (state_q)
				ST_IDLE: if (start) begin
					ip_q <= source_ip; now_q <= now;
					ptr_q <= '0; removed_q <= '0;
					matched_q <= 1'b0; drop_q <= 1'b0; full_q <= 1'b0;
					found_q <= 1'b0; free_q <= 1'b0;
					if (func == FUNC_CONN && is_new &&
						(pol_cost_q != '0 || src_cost_q != '0)) matched_q <= 1'b1;
				end
				ST_SWEEP, ST_SWEEP_LAST: begin
					if (state_q == ST_SWEEP) begin
						ptr_q <= ptr_q + AW'(1);
						valid_rd_q <= 1'b1;
					end
					// judge the entry read last cycle
					if (valid_rd_q && valid_q[rd_idx_q] &&
						!(now_q - rd_exp_q >= 32'h8000_0000)) begin
						valid_q[rd_idx_q]  <= 1'b0;
						reload_q[rd_idx_q] <= 1'b0;
						if (removed_q != 9'd511) removed_q <= removed_q + 9'd1;
					end
				end
				ST_POL_REFILL: ;
				ST_POL_DEBIT: begin
					pol_last_q <= now_q;
					if (rres > pol_cost_q) pol_credit_q <= rres - pol_cost_q;
					else begin
						pol_credit_q <= rres; matched_q <= 1'b0; drop_q <= 1'b1;
					end
				end
				ST_SEARCH, ST_SEARCH_LAST: begin
					if (state_q == ST_SEARCH) begin
						ptr_q <= ptr_q + AW'(1);
						valid_rd_q <= 1'b1;
					end
					if (valid_rd_q && !found_q) begin
						if (valid_q[rd_idx_q] && rd_addr_q == ip_q) begin
							found_q <= 1'b1; slot_q <= rd_idx_q;
						end else if (!valid_q[rd_idx_q] && !free_q) begin
							free_q <= 1'b1; slot_q <= rd_idx_q;
						end
					end
				end
				ST_SRC_READ: begin
					ptr_q <= slot_q;
					reload_hit_q <= found_q && reload_q[slot_q];
					if (!found_q && !free_q) full_q <= 1'b1;
					if (found_q || free_q) reload_q[slot_q] <= 1'b0;
					if (!found_q && free_q) valid_q[slot_q] <= 1'b1;
				end
				ST_SRC_REFILL: ;
				ST_SRC_DEBIT: begin
					if (!(src_credit > src_cost_q)) begin
						matched_q <= 1'b0; drop_q <= 1'b1;
					end
				end
				ST_DONE: done <= 1'b1;
				default: ;
			endcase
		end
	end

	// source credit after refill (new entry skips refill)
	always_comb begin
		src_credit = found_q ? rres : src_init_q;
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (state_q == ST_SRC_DEBIT) begin
			mem_addr[slot_q]   <= ip_q;
			mem_last[slot_q]   <= now_q;
			mem_exp[slot_q]    <= now_q + lifetime_q;
			mem_credit[slot_q] <= (src_credit > src_cost_q) ? src_credit - src_cost_q
				: src_credit;
		end
	end

	assign matched       = matched_q;
	assign drop          = drop_q;
	assign table_full    = full_q;
	assign removed_count = removed_q;

`ifndef ASSERT_OFF
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(matched && drop)) else $error("matched with drop");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && table_full) |-> (matched && removed_count == 9'd0))
		else $error("full result malformed");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
`endif
endmodule

// ===== test/dual_token_bucket_conn_limiter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_token_bucket_conn_limiter_unit_test
// Drives connection and sweep events through the limiter under a series of
// register settings. Directed rows cover the reset state, the extremes and
// drop cases; full-table and random phases follow. Each untyped result beat
// is checked against an in-bench model of both buckets and the source table.
// ----------------------------------------------------------------------------
module dual_token_bucket_conn_limiter_unit_test;
	import dtb_pkg::*;

	localparam int ENTRIES   = 256;
	localparam int RATE      = 32;
	localparam int IDLE_LIM  = 20000;
	localparam int SETTLE    = ENTRIES + 16;

	typedef struct packed {
		logic       matched;
		logic       drop;
		logic       table_full;
		logic [8:0] removed;
	} verdict_t;

	typedef enum logic [1:0] {ROW_CONN, ROW_SWEEP, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [31:0] ip;
		logic [31:0] tick;
		logic        is_new;
		reg_idx_t    idx;
		bit          typed;
		verdict_t    want;
	} row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic        func = FUNC_CONN;
	logic [31:0] source_ip = 0;
	logic [31:0] now = 0;
	logic        is_new = 0;
	logic        done;
	logic        matched, drop, table_full;
	logic [8:0]  removed_count;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	// bench copy of registers and state
	logic [31:0] r_pol_cost, r_pol_cap, r_pol_init, r_pol_start;
	logic [31:0] r_src_cost, r_src_cap, r_src_init, r_life;
	logic [31:0] pol_credit, pol_last;
	bit          ent_valid [ENTRIES];
	bit          ent_reload [ENTRIES];
	logic [31:0] ent_addr [ENTRIES];
	logic [31:0] ent_credit [ENTRIES];
	logic [31:0] ent_last [ENTRIES];
	logic [31:0] ent_expiry [ENTRIES];

	verdict_t    pending_q[$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	logic [31:0] tick_base = 0;
	logic [31:0] ip_pool [16];
	bit          no_gaps = 0;

	dual_token_bucket_conn_limiter_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .source_ip(source_ip), .now(now), .is_new(is_new),
		.done(done), .matched(matched), .drop(drop), .table_full(table_full),
		.removed_count(removed_count), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] bucket_refill(logic [31:0] credit, logic [31:0] last,
			logic [31:0] t, logic [31:0] cap);
		logic [31:0] elapsed;
		logic [63:0] sum;
		elapsed = t - last;
		sum = {32'd0, credit} + {32'd0, elapsed} * RATE;
		return (sum > {32'd0, cap}) ? cap : sum[31:0];
	endfunction

	function automatic void limiter_reset();
		r_pol_cost = 0; r_pol_cap = 0; r_pol_init = 0; r_pol_start = 0;
		r_src_cost = 0; r_src_cap = 0; r_src_init = 0; r_life = LIFETIME_RESET;
		pol_credit = 0; pol_last = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			ent_valid[i] = 0;
			ent_reload[i] = 0;
		end
	endfunction

	function automatic void limiter_write(reg_idx_t idx, logic [31:0] v);
		case (idx)
			REG_POLICY_COST:  r_pol_cost = v;
			REG_POLICY_CAP:   r_pol_cap = v;
			REG_POLICY_INIT:  r_pol_init = v;
			REG_POLICY_START: r_pol_start = v;
			REG_SOURCE_COST:  r_src_cost = v;
			REG_SOURCE_CAP:   r_src_cap = v;
			REG_SOURCE_INIT:  r_src_init = v;
			default:          r_life = v;
		endcase
		if (idx <= REG_POLICY_START) begin
			pol_credit = r_pol_init;
			pol_last = r_pol_start;
		end else if (idx != REG_LIFETIME) begin
			for (int i = 0; i < ENTRIES; i++)
				ent_reload[i] = 1;
		end
	endfunction

	function automatic verdict_t limiter_decide(logic f, logic [31:0] ip, logic [31:0] t,
			logic nw);
		verdict_t v;
		int slot;
		bit found, got_free;
		v = '0;
		slot = 0;
		found = 0;
		got_free = 0;
		if (f == FUNC_SWEEP) begin
			// free every entry whose expiry tick is reached
			for (int i = 0; i < ENTRIES; i++)
				if (ent_valid[i] && ((t - ent_expiry[i]) < 32'h8000_0000)) begin
					ent_valid[i] = 0;
					ent_reload[i] = 0;
					v.removed++;
				end
		end else if (nw && (r_pol_cost != 0 || r_src_cost != 0)) begin
			v.matched = 1;
			if (r_pol_cost != 0) begin
				pol_credit = bucket_refill(pol_credit, pol_last, t, r_pol_cap);
				pol_last = t;
				if (pol_credit > r_pol_cost) pol_credit -= r_pol_cost;
				else begin
					v.matched = 0;
					v.drop = 1;
				end
			end
			if (v.matched && r_src_cost != 0) begin
				for (int i = 0; i < ENTRIES && !found; i++)
					if (ent_valid[i] && ent_addr[i] == ip) begin
						slot = i;
						found = 1;
					end
				if (found) begin
					if (ent_reload[slot]) begin
						ent_credit[slot] = r_src_init;
						ent_reload[slot] = 0;
					end
					ent_expiry[slot] = t + r_life;
					ent_credit[slot] = bucket_refill(ent_credit[slot], ent_last[slot], t,
						r_src_cap);
					ent_last[slot] = t;
				end else begin
					for (int i = 0; i < ENTRIES && !got_free; i++)
						if (!ent_valid[i]) begin
							slot = i;
							got_free = 1;
						end
					if (got_free) begin
						ent_valid[slot] = 1;
						ent_reload[slot] = 0;
						ent_addr[slot] = ip;
						ent_credit[slot] = r_src_init;
						ent_last[slot] = t;
						ent_expiry[slot] = t + r_life;
					end else v.table_full = 1;
				end
				if (found || got_free) begin
					if (ent_credit[slot] > r_src_cost) ent_credit[slot] -= r_src_cost;
					else begin
						v.matched = 0;
						v.drop = 1;
					end
				end
			end
		end
		return v;
	endfunction

	// one event beat; start stays high across back-to-back events
	task automatic send_event(logic f, logic [31:0] ip, logic [31:0] t, logic nw,
			bit typed, verdict_t want);
		int gap;
		verdict_t v;
		gap = no_gaps ? 0 : (($urandom_range(0, 11) == 0) ? $urandom_range(20, 80)
			: $urandom_range(0, 2));
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		func <= f;
		source_ip <= ip;
		now <= t;
		is_new <= nw;
		do @(posedge clk); while (busy);
		v = limiter_decide(f, ip, t, nw);
		pending_q.push_back(typed ? want : v);
	endtask

	// register beat, only while nothing is in flight
	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		start <= 0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		limiter_write(idx, v);
		cfg_valid <= 0;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			3: return $urandom_range(1, 5);
			default: return $urandom_range(0, 400);
		endcase
	endfunction

	// result check
	always @(posedge clk) begin
		verdict_t want, got;
		if (arst_n && done) begin
			got = '{matched, drop, table_full, removed_count};
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", got);
			end else begin
				want = pending_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIM) begin
				$display("dual_token_bucket_conn_limiter_unit_test: errors");
				$finish;
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		verdict_t none;
		int n_items;
		none = '0;

		// directed table
		rows = '{
			'{ROW_CONN, 32'h0, 32'h0, 1'b1, REG_POLICY_COST, 1, '0},
			'{ROW_SWEEP, 32'h0, 32'hFFFF_FFFF, 1'b0, REG_POLICY_COST, 1, '0},
			'{ROW_CONN, 32'hFFFF_FFFF, 32'h5, 1'b0, REG_POLICY_COST, 1, '0},
			'{ROW_REG, 0, 32'd10, 0, REG_POLICY_COST, 0, '0},
			'{ROW_REG, 0, 32'd1000, 0, REG_POLICY_CAP, 0, '0},
			'{ROW_REG, 0, 32'd5, 0, REG_POLICY_INIT, 0, '0},
			'{ROW_REG, 0, 32'd0, 0, REG_POLICY_START, 0, '0},
			// stale start time, no elapsed ticks: credit below cost
			'{ROW_CONN, 32'h1, 32'h0, 1'b1, REG_POLICY_COST, 1, 12'b010_000000000},
			'{ROW_CONN, 32'h1, 32'd100, 1'b1, REG_POLICY_COST, 0, '0},
			'{ROW_CONN, 32'h1, 32'd101, 1'b0, REG_POLICY_COST, 1, '0},
			'{ROW_REG, 0, 32'd1, 0, REG_SOURCE_COST, 0, '0},
			'{ROW_REG, 0, 32'hFFFF_FFFF, 0, REG_SOURCE_CAP, 0, '0},
			'{ROW_REG, 0, 32'hFFFF_FFFF, 0, REG_SOURCE_INIT, 0, '0},
			'{ROW_REG, 0, 32'd1, 0, REG_LIFETIME, 0, '0},
			'{ROW_CONN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, REG_POLICY_COST, 0, '0},
			'{ROW_CONN, 32'h0, 32'h0, 1'b1, REG_POLICY_COST, 0, '0},
			'{ROW_CONN, 32'h0, 32'h1, 1'b1, REG_POLICY_COST, 0, '0},
			'{ROW_SWEEP, 32'h0, 32'h2, 1'b0, REG_POLICY_COST, 0, '0},
			// global cost at max never passes
			'{ROW_REG, 0, 32'hFFFF_FFFF, 0, REG_POLICY_COST, 0, '0},
			'{ROW_REG, 0, 32'hFFFF_FFFF, 0, REG_POLICY_CAP, 0, '0},
			'{ROW_CONN, 32'h7, 32'h8000_0000, 1'b1, REG_POLICY_COST, 1,
				12'b010_000000000},
			'{ROW_REG, 0, 32'd0, 0, REG_POLICY_COST, 0, '0},
			'{ROW_REG, 0, 32'hFFFF_FFFF, 0, REG_SOURCE_COST, 0, '0},
			'{ROW_CONN, 32'h9, 32'h10, 1'b1, REG_POLICY_COST, 1, 12'b010_000000000},
			'{ROW_SWEEP, 32'h0, 32'h7FFF_FFFF, 1'b0, REG_POLICY_COST, 0, '0}
		};

		limiter_reset();
		for (int i = 0; i < 16; i++) ip_pool[i] = $urandom;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i]) begin
			r = rows[i];
			if (r.kind == ROW_REG) write_reg(r.idx, r.tick);
			else send_event(r.kind == ROW_SWEEP, r.ip, r.tick, r.is_new, r.typed, r.want);
		end

		// full table: long lifetime, new sources fill the table until it reports full
		write_reg(REG_LIFETIME, 32'h4000_0000);
		write_reg(REG_SOURCE_COST, 32'd1);
		write_reg(REG_SOURCE_INIT, 32'd100);
		for (int i = 0; i < ENTRIES + 6; i++)
			send_event(FUNC_CONN, 32'h0A00_0000 + i, tick_base + i, 1'b1, 0, none);
		send_event(FUNC_SWEEP, 0, tick_base + 32'h4000_1000, 1'b0, 0, none);
		tick_base += 32'h4000_2000;

		// random phases, new settings between them
		n_items = 0;
		while (n_items < 1550) begin
			for (int k = 0; k < 8; k++)
				if ($urandom_range(0, 2) != 0) write_reg(reg_idx_t'(k), pick_value());
			if ($urandom_range(0, 2) == 0) write_reg(REG_LIFETIME, $urandom_range(1, 3000));
			if (r_pol_cost == 0 && r_src_cost == 0)
				write_reg(REG_SOURCE_COST, $urandom_range(1, 5));
			for (int i = 0; i < 16; i++)
				if ($urandom_range(0, 3) == 0) ip_pool[i] = $urandom;
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 200; i++) begin
				logic [31:0] ip, t;
				tick_base += ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 60);
				t = tick_base;
				ip = ($urandom_range(0, 7) == 0) ? $urandom : ip_pool[$urandom_range(0, 15)];
				if ($urandom_range(0, 24) == 0)
					send_event(FUNC_SWEEP, $urandom, t, $urandom_range(0, 1), 0, none);
				else
					send_event(FUNC_CONN, ip, t, $urandom_range(0, 9) != 0, 0, none);
				n_items++;
			end
		end

		start <= 0;
		no_gaps = 0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending_q.size() == 0)
			$display("dual_token_bucket_conn_limiter_unit_test: clean");
		else
			$display("dual_token_bucket_conn_limiter_unit_test: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/dtb_pkg.sv
design/dtb_refill.sv
design/dual_token_bucket_conn_limiter_unit.sv
test/dual_token_bucket_conn_limiter_unit_test.sv
